/* rtl/kt_pkg.sv */
// Package for the keyword tokenizer: beat types, token codes, keyword table.
`default_nettype none
package kt_pkg;

  localparam int NumKw   = 50;
  localparam int KwBytes = 7;

  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_input;
  } src_beat_t;

  typedef struct packed {
    logic [4:0] token_kind;
    logic [5:0] keyword_index;
    logic [7:0] text_char;
    logic       has_char;
    logic       last;
    logic [1:0] error_cause;
  } tok_beat_t;

  localparam logic [4:0] K_EOF     = 5'd0;
  localparam logic [4:0] K_EOL     = 5'd1;
  localparam logic [4:0] K_LPAREN  = 5'd2;
  localparam logic [4:0] K_RPAREN  = 5'd3;
  localparam logic [4:0] K_COMMA   = 5'd4;
  localparam logic [4:0] K_SEMI    = 5'd5;
  localparam logic [4:0] K_COLON   = 5'd6;
  localparam logic [4:0] K_IDENT   = 5'd7;
  localparam logic [4:0] K_KEYWORD = 5'd8;
  localparam logic [4:0] K_NUMBER  = 5'd9;
  localparam logic [4:0] K_STRING  = 5'd10;
  localparam logic [4:0] K_PLUS    = 5'd11;
  localparam logic [4:0] K_MINUS   = 5'd12;
  localparam logic [4:0] K_STAR    = 5'd13;
  localparam logic [4:0] K_SLASH   = 5'd14;
  localparam logic [4:0] K_CARET   = 5'd15;
  localparam logic [4:0] K_LT      = 5'd16;
  localparam logic [4:0] K_LE      = 5'd17;
  localparam logic [4:0] K_EQ      = 5'd18;
  localparam logic [4:0] K_NE      = 5'd19;
  localparam logic [4:0] K_GT      = 5'd20;
  localparam logic [4:0] K_GE      = 5'd21;
  localparam logic [4:0] K_ERROR   = 5'd22;

  localparam logic [1:0] E_NONE       = 2'd0;
  localparam logic [1:0] E_UNEXPECTED = 2'd1;
  localparam logic [1:0] E_UNTERM     = 2'd2;
  localparam logic [1:0] E_TOO_LONG   = 2'd3;

  localparam logic [2:0] M_IDLE = 3'd0;
  localparam logic [2:0] M_NAME = 3'd1;
  localparam logic [2:0] M_NUM  = 3'd2;
  localparam logic [2:0] M_STR  = 3'd3;
  localparam logic [2:0] M_LT   = 3'd4;
  localparam logic [2:0] M_GT   = 3'd5;

  localparam logic [NumKw-1:0] ALL_KW = '1;

  // spellings right-justified: last character in bits [7:0]
  localparam logic [55:0] KW_ROM [NumKw] = '{
    56'("and"), 56'("or"), 56'("not"), 56'("bye"), 56'("clr"),
    56'("cls"), 56'("cont"), 56'("data"), 56'("dim"), 56'("end"),
    56'("for"), 56'("to"), 56'("step"), 56'("gosub"), 56'("goto"),
    56'("if"), 56'("then"), 56'("input"), 56'("let"), 56'("list"),
    56'("load"), 56'("new"), 56'("next"), 56'("on"), 56'("pop"),
    56'("print"), 56'("read"), 56'("rem"), 56'("restore"), 56'("return"),
    56'("run"), 56'("save"), 56'("stop"), 56'("trap"), 56'("abs"),
    56'("asc"), 56'("atn"), 56'("clog"), 56'("cos"), 56'("exp"),
    56'("int"), 56'("len"), 56'("log"), 56'("rnd"), 56'("sgn"),
    56'("sin"), 56'("sqr"), 56'("val"), 56'("chr$"), 56'("str$")
  };

  localparam logic [2:0] KW_LEN [NumKw] = '{
    3'd3, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3,
    3'd3, 3'd2, 3'd4, 3'd5, 3'd4, 3'd2, 3'd4, 3'd5, 3'd3, 3'd4,
    3'd4, 3'd3, 3'd4, 3'd2, 3'd3, 3'd5, 3'd4, 3'd3, 3'd7, 3'd6,
    3'd3, 3'd4, 3'd4, 3'd4, 3'd3, 3'd3, 3'd3, 3'd4, 3'd3, 3'd3,
    3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4
  };

  // character p of keyword k, zero past its end
  function automatic logic [7:0] kw_byte(input int k, input logic [2:0] p);
    logic [2:0] sh;
    sh = KW_LEN[k] - 3'd1 - p;
    if (p < KW_LEN[k]) return KW_ROM[k][{sh, 3'b000} +: 8];
    return 8'd0;
  endfunction

  function automatic tok_beat_t plain(input logic [4:0] kind, input logic [1:0] cause);
    tok_beat_t t;
    t = '0;
    t.token_kind = kind;
    t.last = 1'b1;
    t.error_cause = cause;
    return t;
  endfunction

endpackage
`default_nettype wire

/* rtl/kt_ram.sv */
// Generic single-port-write, registered-read RAM.
`default_nettype none
module kt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

/* rtl/keyword_tokenizer.sv */
// Streaming lexer for a small BASIC dialect: source bytes in, token beats out.
//
//   channel | dir | payload          | handshake
//   src     | in  | char, end flag   | src_valid / src_stall
//   tok     | out | one token beat   | tok_valid / tok_stall
//
// Each source beat is accepted in S_IN; a beat that only extends pending text
// needs nothing more. Closing a token replays each text character through S_RD
// (text RAM read) then S_EMIT (output register load), or passes S_ONE for a
// single-beat token; a byte then handled from idle passes S_IDLE, then S_ONE
// if it makes a token. Reset (rst, synchronous) clears control state only; text
// RAM content is never read before being written. Output stalls stretch each
// load; src is stalled whenever a byte is in work.
`default_nettype none
module keyword_tokenizer #(
  parameter int MAX_TEXT = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              src_valid,
  output      logic              src_stall,
  input  wire kt_pkg::src_beat_t src_data,
  output      logic              tok_valid,
  input  wire logic              tok_stall,
  output      kt_pkg::tok_beat_t tok_data
);
  import kt_pkg::*;

  localparam int AW = $clog2(MAX_TEXT);
  localparam int LW = $clog2(MAX_TEXT + 1);
  localparam logic [LW-1:0] LEN_MAX = LW'(MAX_TEXT);

  localparam logic [2:0] S_IN   = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_ONE  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]       state, state_next;
  logic [2:0]       mode, mode_next;
  logic [LW-1:0]    len, len_next;
  logic [LW-1:0]    idx, idx_next;
  logic [NumKw-1:0] cand, cand_next;
  logic             then_idle, then_idle_next;
  logic [4:0]       run_kind, run_kind_next;
  tok_beat_t        pend, pend_next;
  logic [7:0]       ch;
  logic             eoi;

  logic             wr_en, rd_en;
  logic [AW-1:0]    wr_addr;
  logic [7:0]       wr_data, rd_data;

  logic             free, load;
  tok_beat_t        load_beat;

  logic [7:0]       c, lc;
  logic             e, is_alpha, is_digit, is_blank;
  logic [NumKw-1:0] match, hit;
  logic [5:0]       kw_idx;
  logic [2:0]       pos;

  kt_ram #(.WIDTH(8), .DEPTH(MAX_TEXT)) u_text (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_en(rd_en), .rd_addr(idx[AW-1:0]), .rd_data(rd_data)
  );

  assign src_stall = (state != S_IN);
  assign free      = !tok_valid || !tok_stall;

  // character under work: the live input when accepting, else the latched one
  always_comb begin
    c = (state == S_IN) ? src_data.in_char : ch;
    e = (state == S_IN) ? src_data.end_of_input : eoi;
    lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    is_digit = (c >= "0" && c <= "9");
    is_blank = (c == " ") || (c == 8'd9) || (c == 8'd11) || (c == 8'd12) || (c == 8'd13);
    pos = (state == S_IN) ? len[2:0] : 3'd0;
    for (int k = 0; k < NumKw; k++) begin
      match[k] = (kw_byte(k, pos) == lc);
      hit[k]   = cand[k] && (LW'(KW_LEN[k]) == len);
    end
    kw_idx = '0;
    for (int k = 0; k < NumKw; k++)
      if (hit[k]) kw_idx = kw_idx | 6'(k);
  end

  always_comb begin
    state_next     = state;
    mode_next      = mode;
    len_next       = len;
    idx_next       = idx;
    cand_next      = cand;
    then_idle_next = then_idle;
    run_kind_next  = run_kind;
    pend_next      = pend;
    wr_en          = 1'b0;
    wr_addr        = len[AW-1:0];
    wr_data        = c;
    rd_en          = 1'b0;
    load           = 1'b0;
    load_beat      = pend;

    unique case (state)
      S_IN: begin
        if (src_valid) begin
          // default: close pending text then handle the byte from idle
          state_next = S_IDLE;
          mode_next  = M_IDLE;
          unique case (mode)
            M_NAME: begin
              if (!e && (is_alpha || is_digit || c == "$") && len < LEN_MAX) begin
                state_next = S_IN;
                mode_next  = M_NAME;
                wr_en      = 1'b1;
                len_next   = len + LW'(1);
                cand_next  = (len < LW'(KwBytes)) ? (cand & match) : '0;
              end else if (|hit) begin
                pend_next = plain(K_KEYWORD, E_NONE);
                pend_next.keyword_index = kw_idx;
                then_idle_next = 1'b1;
                state_next = S_ONE;
              end else begin
                run_kind_next = K_IDENT;
                then_idle_next = 1'b1;
                idx_next = '0;
                state_next = S_RD;
              end
            end
            M_NUM: begin
              if (!e && (is_digit || c == ".")) begin
                if (len < LEN_MAX) begin
                  state_next = S_IN;
                  mode_next  = M_NUM;
                  wr_en      = 1'b1;
                  len_next   = len + LW'(1);
                end else begin
                  pend_next = plain(K_ERROR, E_TOO_LONG);
                  then_idle_next = 1'b0;
                  len_next = '0;
                  state_next = S_ONE;
                end
              end else begin
                run_kind_next = K_NUMBER;
                then_idle_next = 1'b1;
                idx_next = '0;
                state_next = S_RD;
              end
            end
            M_STR: begin
              if (e || c == 8'h0a) begin
                pend_next = plain(K_ERROR, E_UNTERM);
                then_idle_next = 1'b1;
                state_next = S_ONE;
              end else if (c == "\"") begin
                then_idle_next = 1'b0;
                if (len == '0) begin
                  pend_next = plain(K_STRING, E_NONE);
                  state_next = S_ONE;
                end else begin
                  run_kind_next = K_STRING;
                  idx_next = '0;
                  state_next = S_RD;
                end
              end else if (len < LEN_MAX) begin
                state_next = S_IN;
                mode_next  = M_STR;
                wr_en      = 1'b1;
                len_next   = len + LW'(1);
              end else begin
                pend_next = plain(K_ERROR, E_TOO_LONG);
                then_idle_next = 1'b0;
                len_next = '0;
                state_next = S_ONE;
              end
            end
            M_LT: begin
              state_next = S_ONE;
              if (!e && (c == "=" || c == ">")) begin
                pend_next = plain((c == "=") ? K_LE : K_NE, E_NONE);
                then_idle_next = 1'b0;
              end else begin
                pend_next = plain(K_LT, E_NONE);
                then_idle_next = 1'b1;
              end
            end
            M_GT: begin
              state_next = S_ONE;
              if (!e && c == "=") begin
                pend_next = plain(K_GE, E_NONE);
                then_idle_next = 1'b0;
              end else begin
                pend_next = plain(K_GT, E_NONE);
                then_idle_next = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_IDLE: begin
        mode_next = M_IDLE;
        len_next  = '0;
        then_idle_next = 1'b0;
        state_next = S_ONE;
        if (e) begin
          pend_next = plain(K_EOF, E_NONE);
          cand_next = ALL_KW;
        end else if (is_blank) begin
          state_next = S_IN;
        end else begin
          unique case (c)
            8'h0a: pend_next = plain(K_EOL, E_NONE);
            "(":   pend_next = plain(K_LPAREN, E_NONE);
            ")":   pend_next = plain(K_RPAREN, E_NONE);
            ",":   pend_next = plain(K_COMMA, E_NONE);
            ";":   pend_next = plain(K_SEMI, E_NONE);
            ":":   pend_next = plain(K_COLON, E_NONE);
            "+":   pend_next = plain(K_PLUS, E_NONE);
            "-":   pend_next = plain(K_MINUS, E_NONE);
            "*":   pend_next = plain(K_STAR, E_NONE);
            "/":   pend_next = plain(K_SLASH, E_NONE);
            "^":   pend_next = plain(K_CARET, E_NONE);
            "=":   pend_next = plain(K_EQ, E_NONE);
            "<": begin mode_next = M_LT; state_next = S_IN; end
            ">": begin mode_next = M_GT; state_next = S_IN; end
            "\"": begin mode_next = M_STR; state_next = S_IN; end
            default: begin
              if (is_alpha || is_digit) begin
                mode_next  = is_alpha ? M_NAME : M_NUM;
                state_next = S_IN;
                wr_en      = 1'b1;
                wr_addr    = '0;
                len_next   = LW'(1);
                if (is_alpha) cand_next = match;
              end else begin
                pend_next = plain(K_ERROR, E_UNEXPECTED);
              end
            end
          endcase
        end
      end
      S_ONE: begin
        if (free) begin
          load = 1'b1;
          state_next = then_idle ? S_IDLE : S_IN;
        end
      end
      S_RD: begin
        rd_en = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (free) begin
          load = 1'b1;
          load_beat = '0;
          load_beat.token_kind = run_kind;
          load_beat.text_char = rd_data;
          load_beat.has_char = 1'b1;
          load_beat.last = (idx + LW'(1) == len);
          idx_next = idx + LW'(1);
          if (idx + LW'(1) == len) begin
            len_next = '0;
            state_next = then_idle ? S_IDLE : S_IN;
          end else begin
            state_next = S_RD;
          end
        end
      end
      default: state_next = S_IN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IN;
      mode <= M_IDLE;
      len <= '0;
      cand <= ALL_KW;
      tok_valid <= 1'b0;
    end else begin
      state <= state_next;
      mode <= mode_next;
      len <= len_next;
      cand <= cand_next;
      if (load) tok_valid <= 1'b1;
      else if (!tok_stall) tok_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    then_idle <= then_idle_next;
    run_kind <= run_kind_next;
    pend <= pend_next;
    if (state == S_IN && src_valid) begin
      ch <= src_data.in_char;
      eoi <= src_data.end_of_input;
    end
    if (load) tok_data <= load_beat;
  end
endmodule
`default_nettype wire

/* rtl/kt_checker.sv */
// Port-level checks for the keyword tokenizer, bound to the top level.
`default_nettype none
module kt_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              src_valid,
  input wire logic              src_stall,
  input wire kt_pkg::src_beat_t src_data,
  input wire logic              tok_valid,
  input wire logic              tok_stall,
  input wire kt_pkg::tok_beat_t tok_data
);
  import kt_pkg::*;

  logic       open_run;
  logic [4:0] open_kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      open_run <= 1'b0;
      open_kind <= K_EOF;
    end else if (tok_valid && !tok_stall) begin
      open_run <= !tok_data.last;
      open_kind <= tok_data.token_kind;
    end
  end

  a_reset_quiet: assert property (@(posedge clk) rst |=> !tok_valid)
    else $error("token beat right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_stall |=> tok_valid && $stable(tok_data))
    else $error("stalled token beat changed");

  a_src_hold: assert property (@(posedge clk) disable iff (rst)
    src_valid && src_stall |=> src_valid && $stable(src_data))
    else $error("stalled source beat changed");

  a_run_kind: assert property (@(posedge clk) disable iff (rst)
    tok_valid && open_run |-> tok_data.token_kind == open_kind && tok_data.has_char)
    else $error("text run broken by another token");

  a_kw_index: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_data.token_kind != K_KEYWORD |-> tok_data.keyword_index == 6'd0)
    else $error("keyword index on non-keyword beat");
endmodule

bind keyword_tokenizer kt_checker u_kt_checker (
  .clk(clk), .rst(rst), .src_valid(src_valid), .src_stall(src_stall),
  .src_data(src_data), .tok_valid(tok_valid), .tok_stall(tok_stall),
  .tok_data(tok_data)
);
`default_nettype wire
